FILE: design/clip_fade_gain_mixer_macros.svh
// Assertion macros used by the mixer divider RTL.
`ifndef CLIP_FADE_GAIN_MIXER_MACROS_SVH
`define CLIP_FADE_GAIN_MIXER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define CFGM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define CFGM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cfgm_pkg.sv
// Shared types and constants for the clip fade/gain mixer.
package cfgm_pkg;

  // Fixed field widths
  localparam int LEN_W     = 24;  // fade lengths
  localparam int RO_W      = 31;  // read offset
  localparam int FOB_W     = 32;  // fade-out begin, signed
  localparam int GAIN_W    = 20;  // Q4.16 gain
  localparam int RAMP_FRAC = 16;  // ramp fraction bits
  localparam int RAMP_W    = RAMP_FRAC + 1;
  localparam int DIV_STEPS = 2;   // quotient bits per divider stage
  localparam int REG_IDX_W = 3;

  localparam logic [RAMP_W-1:0]       RAMP_ONE   = {1'b1, {RAMP_FRAC{1'b0}}};
  localparam logic signed [FOB_W-1:0] FOB_RESET  = 32'sd1;
  localparam logic [GAIN_W-1:0]       GAIN_RESET = 20'h10000;

  // Register map index
  typedef enum logic [REG_IDX_W-1:0] {
    REG_REGION_START    = 3'd0,
    REG_REGION_END      = 3'd1,
    REG_READ_OFFSET     = 3'd2,
    REG_FADE_IN_LENGTH  = 3'd3,
    REG_FADE_OUT_LENGTH = 3'd4,
    REG_FADE_OUT_BEGIN  = 3'd5,
    REG_GAIN_LEFT       = 3'd6,
    REG_GAIN_RIGHT      = 3'd7
  } reg_idx_t;

  // Fixed-width configuration bundle
  typedef struct packed {
    logic [RO_W-1:0]         read_offset;
    logic [LEN_W-1:0]        fade_in_length;
    logic [LEN_W-1:0]        fade_out_length;
    logic signed [FOB_W-1:0] fade_out_begin;
    logic [GAIN_W-1:0]       gain_left;
    logic [GAIN_W-1:0]       gain_right;
  } cfg_fix_t;

endpackage

FILE: design/cfgm_regs.sv
// APB-style configuration register file.
module cfgm_regs import cfgm_pkg::*; #(
  parameter int POS_W  = 40,
  parameter int DATA_W = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [POS_W-1:0]  region_start,
  output logic [POS_W-1:0]  region_end,
  output cfg_fix_t          cfg
);

  localparam int IDX_LSB = ADDR_W - REG_IDX_W;

  logic [POS_W-1:0]        region_start_r;
  logic [POS_W-1:0]        region_end_r;
  logic [RO_W-1:0]         read_offset_r;
  logic [LEN_W-1:0]        fade_in_length_r;
  logic [LEN_W-1:0]        fade_out_length_r;
  logic signed [FOB_W-1:0] fade_out_begin_r;
  logic [GAIN_W-1:0]       gain_left_r;
  logic [GAIN_W-1:0]       gain_right_r;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:IDX_LSB]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r    <= '0;
      region_end_r      <= '0;
      read_offset_r     <= '0;
      fade_in_length_r  <= '0;
      fade_out_length_r <= '0;
      fade_out_begin_r  <= FOB_RESET;
      gain_left_r       <= GAIN_RESET;
      gain_right_r      <= GAIN_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_REGION_START:    region_start_r    <= pwdata[POS_W-1:0];
        REG_REGION_END:      region_end_r      <= pwdata[POS_W-1:0];
        REG_READ_OFFSET:     read_offset_r     <= pwdata[RO_W-1:0];
        REG_FADE_IN_LENGTH:  fade_in_length_r  <= pwdata[LEN_W-1:0];
        REG_FADE_OUT_LENGTH: fade_out_length_r <= pwdata[LEN_W-1:0];
        REG_FADE_OUT_BEGIN:  fade_out_begin_r  <= $signed(pwdata[FOB_W-1:0]);
        REG_GAIN_LEFT:       gain_left_r       <= pwdata[GAIN_W-1:0];
        REG_GAIN_RIGHT:      gain_right_r      <= pwdata[GAIN_W-1:0];
      endcase
    end
  end

  // Read mux, zero-extended
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_REGION_START:    prdata = DATA_W'(region_start_r);
      REG_REGION_END:      prdata = DATA_W'(region_end_r);
      REG_READ_OFFSET:     prdata = DATA_W'(read_offset_r);
      REG_FADE_IN_LENGTH:  prdata = DATA_W'(fade_in_length_r);
      REG_FADE_OUT_LENGTH: prdata = DATA_W'(fade_out_length_r);
      REG_FADE_OUT_BEGIN:  prdata = DATA_W'($unsigned(fade_out_begin_r));
      REG_GAIN_LEFT:       prdata = DATA_W'(gain_left_r);
      REG_GAIN_RIGHT:      prdata = DATA_W'(gain_right_r);
    endcase
  end

  assign region_start        = region_start_r;
  assign region_end          = region_end_r;
  assign cfg.read_offset     = read_offset_r;
  assign cfg.fade_in_length  = fade_in_length_r;
  assign cfg.fade_out_length = fade_out_length_r;
  assign cfg.fade_out_begin  = fade_out_begin_r;
  assign cfg.gain_left       = gain_left_r;
  assign cfg.gain_right      = gain_right_r;

endmodule

FILE: design/cfgm_front.sv
// Region check, read index and fade ramp operand selection (four stages).
module cfgm_front import cfgm_pkg::*; #(
  parameter int POS_W = 40,
  parameter int SMP_W = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [SMP_W-1:0] in_mix_left,
  input  logic signed [SMP_W-1:0] in_mix_right,
  input  logic signed [SMP_W-1:0] in_clip_left,
  input  logic signed [SMP_W-1:0] in_clip_right,
  input  logic                    in_sample_present,
  input  logic [POS_W-1:0]        region_start,
  input  logic [POS_W-1:0]        region_end,
  input  cfg_fix_t                cfg,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [LEN_W-1:0]        out_num,
  output logic [LEN_W-1:0]        out_den,
  output logic                    out_bypass,
  output logic [4*SMP_W:0]        out_tag
);

  localparam int RW   = ((POS_W > RO_W) ? POS_W : RO_W) + 1;  // read index
  localparam int DW   = RW + 1;                               // index minus begin
  localparam int SMPS = 4 * SMP_W;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  // Stage 1: offset into region, region hit
  logic [POS_W-1:0] k1_r;
  logic             inr1_r;
  logic [SMPS-1:0]  smp1_r;
  // Stage 2: read index, fade-in hit
  logic [RW-1:0]    r2_r;
  logic [LEN_W-1:0] klo2_r;
  logic             fi2_r;
  logic             inr2_r;
  logic [SMPS-1:0]  smp2_r;
  // Stage 3: distance past fade-out begin
  logic signed [DW-1:0] diff3_r;
  logic [LEN_W-1:0]     klo3_r;
  logic                 fi3_r;
  logic                 inr3_r;
  logic [SMPS-1:0]      smp3_r;
  // Stage 4: divider operands
  logic [LEN_W-1:0] num4_r, den4_r;
  logic             byp4_r;
  logic             inr4_r;
  logic [SMPS-1:0]  smp4_r;

  logic [POS_W-1:0]     k_nxt;
  logic                 inr_nxt;
  logic [RW-1:0]        r_nxt;
  logic                 fi_nxt;
  logic signed [DW-1:0] fob_ext;
  logic signed [DW-1:0] diff_nxt;
  logic signed [DW-1:0] fol_ext;
  logic                 fo_on;
  logic                 d_big;
  logic [LEN_W-1:0]     fo_num;
  logic [LEN_W-1:0]     num_nxt, den_nxt;
  logic                 byp_nxt;

  // Ready chain: a stage loads when empty or when its successor moves
  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Stage 1 logic
  assign k_nxt   = in_position - region_start;
  assign inr_nxt = (in_position >= region_start) && (in_position <= region_end)
                   && in_sample_present;

  // Stage 2 logic
  assign fi_nxt = k1_r < POS_W'(cfg.fade_in_length);
  assign r_nxt  = RW'(k1_r) + RW'(cfg.read_offset);

  // Stage 3 logic
  assign fob_ext  = {{(DW-FOB_W){cfg.fade_out_begin[FOB_W-1]}}, cfg.fade_out_begin};
  assign diff_nxt = $signed({1'b0, r2_r}) - fob_ext;

  // Stage 4 logic: pick fade-in, fade-out or unity
  assign fol_ext = {{(DW-LEN_W){1'b0}}, cfg.fade_out_length};
  assign fo_on   = !diff3_r[DW-1] && (diff3_r != '0);
  assign d_big   = diff3_r >= fol_ext;
  assign fo_num  = cfg.fade_out_length - diff3_r[LEN_W-1:0];

  always_comb begin
    num_nxt = '0;
    den_nxt = cfg.fade_out_length;
    byp_nxt = 1'b0;
    if (fi3_r) begin
      num_nxt = klo3_r;
      den_nxt = cfg.fade_in_length;
    end else if ((cfg.fade_out_length == '0) || !fo_on) begin
      byp_nxt = 1'b1;
    end else if (!d_big) begin
      num_nxt = fo_num;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en1) begin
      k1_r   <= k_nxt;
      inr1_r <= inr_nxt;
      smp1_r <= {in_mix_left, in_mix_right, in_clip_left, in_clip_right};
    end
    if (en2) begin
      r2_r   <= r_nxt;
      klo2_r <= k1_r[LEN_W-1:0];
      fi2_r  <= fi_nxt;
      inr2_r <= inr1_r;
      smp2_r <= smp1_r;
    end
    if (en3) begin
      diff3_r <= diff_nxt;
      klo3_r  <= klo2_r;
      fi3_r   <= fi2_r;
      inr3_r  <= inr2_r;
      smp3_r  <= smp2_r;
    end
    if (en4) begin
      num4_r <= num_nxt;
      den4_r <= den_nxt;
      byp4_r <= byp_nxt;
      inr4_r <= inr3_r;
      smp4_r <= smp3_r;
    end
  end

  assign out_valid  = v4_r;
  assign out_num    = num4_r;
  assign out_den    = den4_r;
  assign out_bypass = byp4_r;
  assign out_tag    = {inr4_r, smp4_r};

endmodule

FILE: design/cfgm_div.sv
// Pipelined restoring divider: floor(num * 2^16 / den) for num < den.
`include "clip_fade_gain_mixer_macros.svh"
module cfgm_div import cfgm_pkg::*; #(
  parameter int TAG_W = 97
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [LEN_W-1:0]     in_num,
  input  logic [LEN_W-1:0]     in_den,
  input  logic                 in_bypass,
  input  logic [TAG_W-1:0]     in_tag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RAMP_FRAC-1:0] out_quot,
  output logic                 out_bypass,
  output logic [TAG_W-1:0]     out_tag
);

  localparam int STAGES = RAMP_FRAC / DIV_STEPS;
  localparam int LAST   = STAGES - 1;

  logic [STAGES-1:0]    valid_r;
  logic [STAGES-1:0]    en;
  logic [LEN_W-1:0]     rem_r   [STAGES];
  logic [LEN_W-1:0]     den_r   [STAGES];
  logic [RAMP_FRAC-1:0] quo_r   [STAGES];
  logic [STAGES-1:0]    byp_r;
  logic [TAG_W-1:0]     tag_r   [STAGES];
  logic [LEN_W-1:0]     rem_nxt [STAGES];
  logic [RAMP_FRAC-1:0] quo_nxt [STAGES];

  assign in_ready = en[0];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic                 vld_src;
    logic [LEN_W-1:0]     rem_src;
    logic [LEN_W-1:0]     den_src;
    logic [RAMP_FRAC-1:0] quo_src;
    logic                 byp_src;
    logic [TAG_W-1:0]     tag_src;

    // Source of this stage: the input port or the previous stage
    if (s == 0) begin : g_first
      assign vld_src = in_valid;
      assign rem_src = in_num;
      assign den_src = in_den;
      assign quo_src = '0;
      assign byp_src = in_bypass;
      assign tag_src = in_tag;
    end else begin : g_rest
      assign vld_src = valid_r[s-1];
      assign rem_src = rem_r[s-1];
      assign den_src = den_r[s-1];
      assign quo_src = quo_r[s-1];
      assign byp_src = byp_r[s-1];
      assign tag_src = tag_r[s-1];
    end

    // Ready chain
    if (s == LAST) begin : g_en_last
      assign en[s] = !valid_r[s] || out_ready;
    end else begin : g_en_mid
      assign en[s] = !valid_r[s] || en[s+1];
    end

    // Shift-compare-subtract, a few quotient bits per stage
    always_comb begin
      logic [LEN_W-1:0]     rem;
      logic [LEN_W:0]       sh;
      logic [RAMP_FRAC-1:0] quo;
      rem = rem_src;
      quo = quo_src;
      for (int b = 0; b < DIV_STEPS; b++) begin
        sh = {rem, 1'b0};
        if (sh >= {1'b0, den_src}) begin
          sh  = sh - {1'b0, den_src};
          quo = {quo[RAMP_FRAC-2:0], 1'b1};
        end else begin
          quo = {quo[RAMP_FRAC-2:0], 1'b0};
        end
        rem = sh[LEN_W-1:0];
      end
      rem_nxt[s] = rem;
      quo_nxt[s] = quo;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en[s]) begin
        valid_r[s] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s] <= rem_nxt[s];
        den_r[s] <= den_src;
        quo_r[s] <= quo_nxt[s];
        byp_r[s] <= byp_src;
        tag_r[s] <= tag_src;
      end
    end
  end

  assign out_valid  = valid_r[LAST];
  assign out_quot   = quo_r[LAST];
  assign out_bypass = byp_r[LAST];
  assign out_tag    = tag_r[LAST];

  // Front end must hand over a proper fraction
  `CFGM_ASSERT_NOW(a_num_below_den, clk, rst_n, in_valid && in_ready && !in_bypass, in_num < in_den, "divider operand not a proper fraction")
  // Remainder stays below the divisor through the pipe
  `CFGM_ASSERT_NOW(a_rem_below_den, clk, rst_n, valid_r[LAST] && !byp_r[LAST], rem_r[LAST] < den_r[LAST], "divider remainder out of range")
  // Downstream ready must open the whole chain
  `CFGM_ASSERT_NOW(a_chain_open, clk, rst_n, out_ready, in_ready, "divider ready chain blocked")

endmodule

FILE: design/cfgm_mix.sv
// Gain times ramp, sample weighting, rounding and saturating add (three stages).
module cfgm_mix import cfgm_pkg::*; #(
  parameter int SMP_W = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [RAMP_FRAC-1:0]    in_quot,
  input  logic                    in_bypass,
  input  logic [4*SMP_W:0]        in_tag,
  input  logic [GAIN_W-1:0]       gain_left,
  input  logic [GAIN_W-1:0]       gain_right,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] out_left,
  output logic signed [SMP_W-1:0] out_right,
  output logic                    out_contributed
);

  localparam int GP_W = GAIN_W + RAMP_W;        // gain * ramp
  localparam int PW   = SMP_W + GAIN_W + 1;     // sample * gain
  localparam int TW   = PW - RAMP_FRAC;         // rounded term
  localparam int SW   = TW + 1;                 // mix + term
  localparam logic signed [PW-1:0] RND =
    {{(PW-RAMP_FRAC){1'b0}}, 1'b1, {(RAMP_FRAC-1){1'b0}}};
  localparam logic signed [SW-1:0] HI =
    {{(SW-SMP_W+1){1'b0}}, {(SMP_W-1){1'b1}}};
  localparam logic signed [SW-1:0] LO =
    {{(SW-SMP_W+1){1'b1}}, {(SMP_W-1){1'b0}}};

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  // Stage 1: effective gains
  logic [GAIN_W-1:0]       gl1_r, gr1_r;
  logic                    inr1_r;
  logic signed [SMP_W-1:0] ml1_r, mr1_r, cl1_r, cr1_r;
  // Stage 2: weighted samples
  logic signed [PW-1:0]    pl2_r, pr2_r;
  logic                    inr2_r;
  logic signed [SMP_W-1:0] ml2_r, mr2_r;
  // Stage 3: output register
  logic signed [SMP_W-1:0] ol3_r, or3_r;
  logic                    con3_r;

  logic [RAMP_W-1:0]       ramp;
  logic [GP_W-1:0]         gpl, gpr;
  logic signed [GAIN_W:0]  gl_s, gr_s;
  logic signed [PW-1:0]    pl_nxt, pr_nxt;
  logic signed [PW-1:0]    rl, rr;
  logic signed [TW-1:0]    tl, tr;
  logic signed [SMP_W-1:0] ol_nxt, or_nxt;

  function automatic logic signed [SMP_W-1:0] sat_add(
    input logic signed [SMP_W-1:0] mix,
    input logic signed [TW-1:0]    term
  );
    logic signed [SW-1:0] sum;
    sum = SW'(mix) + SW'(term);
    if (sum > HI) begin
      sum = HI;
    end else if (sum < LO) begin
      sum = LO;
    end
    return sum[SMP_W-1:0];
  endfunction

  // Ready chain
  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Stage 1 logic: g = gain * ramp >> 16
  assign ramp = in_bypass ? RAMP_ONE : {1'b0, in_quot};
  assign gpl  = GP_W'(gain_left) * GP_W'(ramp);
  assign gpr  = GP_W'(gain_right) * GP_W'(ramp);

  // Stage 2 logic: clip * g
  assign gl_s   = $signed({1'b0, gl1_r});
  assign gr_s   = $signed({1'b0, gr1_r});
  assign pl_nxt = PW'(cl1_r) * PW'(gl_s);
  assign pr_nxt = PW'(cr1_r) * PW'(gr_s);

  // Stage 3 logic: round half up, add, saturate
  assign rl = pl2_r + RND;
  assign rr = pr2_r + RND;
  assign tl = rl[PW-1:RAMP_FRAC];
  assign tr = rr[PW-1:RAMP_FRAC];
  assign ol_nxt = inr2_r ? sat_add(ml2_r, tl) : ml2_r;
  assign or_nxt = inr2_r ? sat_add(mr2_r, tr) : mr2_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Payload; tag is {in region, mix L, mix R, clip L, clip R}
  always_ff @(posedge clk) begin
    if (en1) begin
      gl1_r  <= gpl[RAMP_FRAC +: GAIN_W];
      gr1_r  <= gpr[RAMP_FRAC +: GAIN_W];
      inr1_r <= in_tag[4*SMP_W];
      ml1_r  <= $signed(in_tag[3*SMP_W +: SMP_W]);
      mr1_r  <= $signed(in_tag[2*SMP_W +: SMP_W]);
      cl1_r  <= $signed(in_tag[SMP_W +: SMP_W]);
      cr1_r  <= $signed(in_tag[0 +: SMP_W]);
    end
    if (en2) begin
      pl2_r  <= pl_nxt;
      pr2_r  <= pr_nxt;
      inr2_r <= inr1_r;
      ml2_r  <= ml1_r;
      mr2_r  <= mr1_r;
    end
    if (en3) begin
      ol3_r  <= ol_nxt;
      or3_r  <= or_nxt;
      con3_r <= inr2_r;
    end
  end

  assign out_valid       = v3_r;
  assign out_left        = ol3_r;
  assign out_right       = or3_r;
  assign out_contributed = con3_r;

endmodule

FILE: design/clip_fade_gain_mixer.sv
// Clip fade/gain mixer top level: config registers and the item pipeline.
// Adds one clip, weighted by a per-channel Q4.16 gain and a linear Q0.16
// fade ramp, into a running stereo Q1.23 mix with saturation. One stereo
// beat is taken per clock while in_ready is high; a beat passes through
// 4 stages of region check and ramp operand selection, 8 stages of the
// pipelined ramp divider (2 quotient bits each), and 3 stages of gain,
// weighting and saturating add. Every stage holds its beat under
// backpressure and empty stages fill while the output is stalled.
// Registers (byte address 8*i when POSITION_BITS > 32, else 4*i):
// 0 region_start, 1 region_end, 2 read_offset, 3 fade_in_length,
// 4 fade_out_length, 5 fade_out_begin, 6 gain_left, 7 gain_right.
// Write registers only while no beat is in flight.
module clip_fade_gain_mixer import cfgm_pkg::*; #(
  parameter int SAMPLE_BITS   = 24,
  parameter int POSITION_BITS = 40,
  localparam int DATA_W = (POSITION_BITS > 32) ? 64 : 32,
  localparam int ADDR_W = REG_IDX_W + ((DATA_W == 64) ? 3 : 2)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [POSITION_BITS-1:0]      in_position,
  input  logic signed [SAMPLE_BITS-1:0] in_mix_left,
  input  logic signed [SAMPLE_BITS-1:0] in_mix_right,
  input  logic signed [SAMPLE_BITS-1:0] in_clip_left,
  input  logic signed [SAMPLE_BITS-1:0] in_clip_right,
  input  logic                          in_sample_present,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  output logic                          out_contributed,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  localparam int TAG_W = 4 * SAMPLE_BITS + 1;

  logic [POSITION_BITS-1:0] region_start;
  logic [POSITION_BITS-1:0] region_end;
  cfg_fix_t                 cfg;

  logic                 fr_valid, fr_ready, fr_bypass;
  logic [LEN_W-1:0]     fr_num, fr_den;
  logic [TAG_W-1:0]     fr_tag;
  logic                 dv_valid, dv_ready, dv_bypass;
  logic [RAMP_FRAC-1:0] dv_quot;
  logic [TAG_W-1:0]     dv_tag;

  // Configuration registers
  cfgm_regs #(
    .POS_W  (POSITION_BITS),
    .DATA_W (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .region_start (region_start),
    .region_end   (region_end),
    .cfg          (cfg)
  );

  // Region check and ramp operands
  cfgm_front #(
    .POS_W (POSITION_BITS),
    .SMP_W (SAMPLE_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_position       (in_position),
    .in_mix_left       (in_mix_left),
    .in_mix_right      (in_mix_right),
    .in_clip_left      (in_clip_left),
    .in_clip_right     (in_clip_right),
    .in_sample_present (in_sample_present),
    .region_start      (region_start),
    .region_end        (region_end),
    .cfg               (cfg),
    .out_valid         (fr_valid),
    .out_ready         (fr_ready),
    .out_num           (fr_num),
    .out_den           (fr_den),
    .out_bypass        (fr_bypass),
    .out_tag           (fr_tag)
  );

  // Fade ramp divider
  cfgm_div #(
    .TAG_W (TAG_W)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (fr_valid),
    .in_ready   (fr_ready),
    .in_num     (fr_num),
    .in_den     (fr_den),
    .in_bypass  (fr_bypass),
    .in_tag     (fr_tag),
    .out_valid  (dv_valid),
    .out_ready  (dv_ready),
    .out_quot   (dv_quot),
    .out_bypass (dv_bypass),
    .out_tag    (dv_tag)
  );

  // Gain, weighting and saturating add
  cfgm_mix #(
    .SMP_W (SAMPLE_BITS)
  ) u_mix (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (dv_valid),
    .in_ready        (dv_ready),
    .in_quot         (dv_quot),
    .in_bypass       (dv_bypass),
    .in_tag          (dv_tag),
    .gain_left       (cfg.gain_left),
    .gain_right      (cfg.gain_right),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left        (out_left),
    .out_right       (out_right),
    .out_contributed (out_contributed)
  );

endmodule
